@@ rtl/core/tlph_pkg.sv @@
// ----------------------------------------------------------------------------
// tlph_pkg
// shared types and constants of the timeline playhead
// ----------------------------------------------------------------------------
package tlph_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int SERIAL_BITS = 32;
  localparam int FW          = 40;

  localparam logic [FW-1:0] FRAME_MAX = {FW{1'b1}};

  typedef enum logic [1:0] {
    RS_STOPPED   = 2'd0,
    RS_PLAYING   = 2'd1,
    RS_PAUSED    = 2'd2,
    RS_COMPLETED = 2'd3
  } run_state_t;

  typedef enum logic [2:0] {
    FN_TICK  = 3'd0,
    FN_PLAY  = 3'd1,
    FN_PAUSE = 3'd2,
    FN_STOP  = 3'd3,
    FN_SEEK  = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    CR_LENGTH  = 3'd0,
    CR_RES     = 3'd1,
    CR_RATE    = 3'd2,
    CR_REVERSE = 3'd3,
    CR_LOOP    = 3'd4,
    CR_SEEKPOL = 3'd5,
    CR_KEEP    = 3'd6,
    CR_ASSET   = 3'd7
  } cfg_idx_t;

  // shared unit operations
  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_DIV = 2'd1
  } op_t;

  typedef struct packed {
    logic       start;
    op_t        op;
    logic [71:0] a;    // multiplicand or dividend
    logic [39:0] b;    // multiplier or divisor
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [71:0] res;  // product or quotient
    logic [39:0] rem;
  } alu_rsp_t;

endpackage

@@ rtl/core/timeline_playhead_unit.sv @@
// ----------------------------------------------------------------------------
// timeline_playhead_unit
// playhead sequencer: run states, tick stepping, looping and range report
// ----------------------------------------------------------------------------
// Usage: events enter on the in_ channel (in_valid/in_stall, in_stall driven
// here). Each accepted word yields exactly one result word on the out_
// channel (out_valid/out_stall, out_stall driven by the receiver).
// Play, pause, stop, seek and ticks that find nothing to move (seek pending,
// not playing, zero length) go from the execute state straight to finish.
// Any other tick runs two 40-step serial multiplies on the shared shift-add
// unit and then the move state; when it wraps a loop a 72-step restoring
// division on the same unit follows before the frame is applied.
// in_stall stays high from acceptance until the result is loaded into the
// output register, and the next word can go in once it is low again.
// The result register holds its word while out_stall is high; a further word
// can then be taken in, but its result waits in the sequencer, in_stall high.
// Configuration words go in through cfg_valid/cfg_ready (always high) with
// cfg_index and cfg_data; software must write only when idle (not enforced).
// Synchronous reset (rst_n low) restores the register defaults, stops the
// playhead at frame zero and clears the range and serial counter.
// ----------------------------------------------------------------------------
module timeline_playhead_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_func,
  input  logic [31:0] in_delta_seconds,
  input  logic [39:0] in_seek_frame,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_run_state,
  output logic [39:0] out_current_frame,
  output logic [39:0] out_range_start,
  output logic [39:0] out_range_end,
  output logic        out_range_valid,
  output logic        out_range_backward,
  output logic        out_range_wrapped,
  output logic [15:0] out_wrap_count,
  output logic        out_by_seek,
  output logic [31:0] out_range_serial,
  output logic        out_suppress_events,
  output logic        out_evaluating,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import tlph_pkg::*;

  typedef enum logic [2:0] {
    SQ_IDLE, SQ_EXEC, SQ_MUL1, SQ_MUL2, SQ_MOVE, SQ_DIV, SQ_FIN, SQ_OUT
  } seq_t;

  seq_t seq_r, seq_nxt;

  // configuration
  logic [23:0] len_r;
  logic [15:0] res_r;
  logic [23:0] rate_r;
  logic rev_r, loop_r, spol_r, keep_r, asset_r;

  // playhead state
  run_state_t phase_r, phase_nxt;
  logic [FW-1:0] frame_r, frame_nxt, fbs_r, fbs_nxt;
  logic seek_r, seek_nxt;
  logic [SERIAL_BITS-1:0] serial_r, serial_nxt, lser_r, lser_nxt;
  logic [FW-1:0] ls_r, ls_nxt, le_r, le_nxt;
  logic fv_r, fv_nxt, fb_r, fb_nxt, fw_r, fw_nxt, fs_r, fs_nxt;
  logic [15:0] lw_r, lw_nxt;

  // captured event and working values
  func_t       func_r, func_nxt;
  logic [31:0] dsec_r, dsec_nxt;
  logic [FW-1:0] skf_r, skf_nxt;
  logic [71:0] wk_r, wk_nxt;        // product or next frame candidate
  logic [FW-1:0] prev_r, prev_nxt;
  logic [71:0] k_r, k_nxt;
  logic out_v_r, out_v_nxt;

  alu_req_t areq;
  alu_rsp_t arsp;

  tlph_alu u_alu (.clk(clk), .rst_n(rst_n), .req(areq), .rsp(arsp));

  logic [FW-1:0] endf;
  logic [FW:0]   lenx;
  logic [71:0]   step;
  logic [72:0]   fwd;
  logic [71:0]   defi, kk;
  logic [FW-1:0] nxt_f;

  always_comb begin
    lenx = {1'b0, len_r, {FRAC_BITS{1'b0}}};
    endf = lenx[FW] ? FRAME_MAX : lenx[FW-1:0];
  end

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0; res_r <= 16'd60; rate_r <= 24'd65536;
      rev_r <= 1'b0; loop_r <= 1'b0; spol_r <= 1'b0; keep_r <= 1'b0;
      asset_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CR_LENGTH:  len_r   <= cfg_data[23:0];
        CR_RES:     res_r   <= cfg_data[15:0];
        CR_RATE:    rate_r  <= cfg_data[23:0];
        CR_REVERSE: rev_r   <= cfg_data[0];
        CR_LOOP:    loop_r  <= cfg_data[0];
        CR_SEEKPOL: spol_r  <= cfg_data[0];
        CR_KEEP:    keep_r  <= cfg_data[0];
        CR_ASSET:   asset_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_stall = (seq_r != SQ_IDLE);

  always_comb begin
    seq_nxt = seq_r;
    phase_nxt = phase_r; frame_nxt = frame_r; fbs_nxt = fbs_r;
    seek_nxt = seek_r; serial_nxt = serial_r; lser_nxt = lser_r;
    ls_nxt = ls_r; le_nxt = le_r; lw_nxt = lw_r;
    fv_nxt = fv_r; fb_nxt = fb_r; fw_nxt = fw_r; fs_nxt = fs_r;
    func_nxt = func_r; dsec_nxt = dsec_r; skf_nxt = skf_r;
    wk_nxt = wk_r; prev_nxt = prev_r; k_nxt = k_r;
    out_v_nxt = out_v_r;
    areq = '0;
    step = '0; fwd = '0; defi = '0; kk = '0; nxt_f = '0;
    unique case (seq_r)
      SQ_IDLE: begin
        if (in_valid) begin
          func_nxt = func_t'(in_func);
          dsec_nxt = in_delta_seconds;
          skf_nxt  = in_seek_frame;
          seq_nxt  = SQ_EXEC;
        end
      end
      SQ_EXEC: begin
        seq_nxt = SQ_FIN;
        case (func_r)
          FN_TICK: begin
            ls_nxt = '0; le_nxt = '0; lw_nxt = '0; lser_nxt = '0;
            fv_nxt = 1'b0; fb_nxt = 1'b0; fw_nxt = 1'b0; fs_nxt = 1'b0;
            prev_nxt = frame_r;
            k_nxt = '0;
            if (seek_r) begin
              ls_nxt = fbs_r; le_nxt = frame_r; fs_nxt = 1'b1;
              fb_nxt = frame_r < fbs_r;
              fv_nxt = frame_r != fbs_r;
              serial_nxt = serial_r + 1'b1;
              lser_nxt = serial_r + 1'b1;
              seek_nxt = 1'b0;
            end else if (phase_r == RS_PLAYING) begin
              if (len_r == '0) begin
                frame_nxt = '0;
                phase_nxt = RS_COMPLETED;
              end else begin
                areq.start = 1'b1; areq.op = OP_MUL;
                areq.a = {40'd0, dsec_r};
                areq.b = {24'd0, res_r};
                seq_nxt = SQ_MUL1;
              end
            end
          end
          FN_PLAY: if (asset_r) begin
            if (phase_r == RS_COMPLETED) frame_nxt = rev_r ? endf : '0;
            phase_nxt = RS_PLAYING;
          end
          FN_PAUSE: if (phase_r == RS_PLAYING) phase_nxt = RS_PAUSED;
          FN_STOP: begin
            frame_nxt = '0; seek_nxt = 1'b0; phase_nxt = RS_STOPPED;
            ls_nxt = '0; le_nxt = '0; lw_nxt = '0; lser_nxt = '0;
            fv_nxt = 1'b0; fb_nxt = 1'b0; fw_nxt = 1'b0; fs_nxt = 1'b0;
          end
          FN_SEEK: begin
            if (!seek_r) fbs_nxt = frame_r;
            frame_nxt = skf_r; seek_nxt = 1'b1;
            ls_nxt = '0; le_nxt = '0; lw_nxt = '0; lser_nxt = '0;
            fv_nxt = 1'b0; fb_nxt = 1'b0; fw_nxt = 1'b0; fs_nxt = 1'b0;
          end
          default: ;
        endcase
      end
      SQ_MUL1: begin
        if (arsp.done) begin
          // dsec*res fits in 48 bits
          areq.start = 1'b1; areq.op = OP_MUL;
          areq.a = arsp.res;
          areq.b = {16'd0, rate_r};
          seq_nxt = SQ_MUL2;
        end
      end
      SQ_MUL2: begin
        if (arsp.done) begin
          wk_nxt = arsp.res;
          seq_nxt = SQ_MOVE;
        end
      end
      SQ_MOVE: begin
        step = wk_r >> (FW - FRAC_BITS);
        seq_nxt = SQ_FIN;
        if (step != '0) begin
          seq_nxt = SQ_OUT;  // commit path reuses SQ_OUT as apply stage
          if (!rev_r) begin
            fwd = {1'b0, step} + {33'd0, prev_r};
            if (!loop_r) begin
              if (fwd >= {33'd0, endf}) begin
                wk_nxt = {32'd0, endf};
                phase_nxt = RS_COMPLETED;
              end else wk_nxt = fwd[71:0];
            end else if (fwd > {33'd0, endf}) begin
              areq.start = 1'b1; areq.op = OP_DIV;
              areq.a = fwd[71:0] - 72'd1;
              areq.b = endf;
              wk_nxt = fwd[71:0];
              seq_nxt = SQ_DIV;
            end else wk_nxt = fwd[71:0];
          end else begin
            if (!loop_r) begin
              if (step >= {32'd0, prev_r}) begin
                wk_nxt = '0;
                phase_nxt = RS_COMPLETED;
              end else wk_nxt = {32'd0, prev_r} - step;
            end else if (step > {32'd0, prev_r}) begin
              defi = step - {32'd0, prev_r};
              areq.start = 1'b1; areq.op = OP_DIV;
              areq.a = defi + {32'd0, endf} - 72'd1;
              areq.b = endf;
              wk_nxt = defi;
              seq_nxt = SQ_DIV;
            end else wk_nxt = {32'd0, prev_r} - step;
          end
        end
      end
      SQ_DIV: begin
        if (arsp.done) begin
          kk = arsp.res;
          k_nxt = kk;
          // next = fwd - k*len, or k*len - deficit; both equal a remainder form
          if (!rev_r) wk_nxt = {32'd0, arsp.rem} + 72'd1;
          else wk_nxt = (arsp.rem == (endf - 40'd1)) ? 72'd0
                        : {32'd0, endf - 40'd1 - arsp.rem};
          seq_nxt = SQ_OUT;
        end
      end
      SQ_OUT: begin
        // apply the moved frame
        nxt_f = (wk_r > {32'd0, endf}) ? endf : wk_r[FW-1:0];
        frame_nxt = nxt_f;
        seq_nxt = SQ_FIN;
        if (nxt_f != prev_r) begin
          ls_nxt = prev_r; le_nxt = nxt_f;
          fv_nxt = 1'b1; fb_nxt = rev_r; fw_nxt = k_r != '0; fs_nxt = 1'b0;
          lw_nxt = (k_r > 72'hFFFF) ? 16'hFFFF : k_r[15:0];
          serial_nxt = serial_r + 1'b1;
          lser_nxt = serial_r + 1'b1;
        end
      end
      SQ_FIN: begin
        if (!out_v_r || !out_stall) begin
          out_v_nxt = 1'b1;
          seq_nxt = SQ_IDLE;
        end
      end
      default: seq_nxt = SQ_IDLE;
    endcase
    if (out_v_r && !out_stall && seq_r != SQ_FIN) out_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= SQ_IDLE; phase_r <= RS_STOPPED; frame_r <= '0; fbs_r <= '0;
      seek_r <= 1'b0; serial_r <= '0; lser_r <= '0; ls_r <= '0; le_r <= '0;
      fv_r <= 1'b0; fb_r <= 1'b0; fw_r <= 1'b0; fs_r <= 1'b0; lw_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      seq_r <= seq_nxt; phase_r <= phase_nxt; frame_r <= frame_nxt;
      fbs_r <= fbs_nxt; seek_r <= seek_nxt; serial_r <= serial_nxt;
      lser_r <= lser_nxt; ls_r <= ls_nxt; le_r <= le_nxt;
      fv_r <= fv_nxt; fb_r <= fb_nxt; fw_r <= fw_nxt; fs_r <= fs_nxt;
      lw_r <= lw_nxt; out_v_r <= out_v_nxt;
    end
    func_r <= func_nxt; dsec_r <= dsec_nxt; skf_r <= skf_nxt;
    wk_r <= wk_nxt; prev_r <= prev_nxt; k_r <= k_nxt;
  end

  // result word register, loaded as the sequencer finishes
  logic [1:0]  o_rs_r;
  logic [39:0] o_cf_r, o_st_r, o_en_r;
  logic        o_v_r, o_b_r, o_w_r, o_s_r, o_sup_r, o_ev_r;
  logic [15:0] o_wc_r;
  logic [31:0] o_ser_r;

  always_ff @(posedge clk) begin
    if (seq_r == SQ_FIN && (!out_v_r || !out_stall)) begin
      o_rs_r  <= phase_r;
      o_cf_r  <= frame_r;
      o_st_r  <= ls_r;
      o_en_r  <= le_r;
      o_v_r   <= fv_r;
      o_b_r   <= fb_r;
      o_w_r   <= fw_r;
      o_wc_r  <= lw_r;
      o_s_r   <= fs_r;
      o_ser_r <= lser_r;
      o_sup_r <= !fv_r || (fs_r && spol_r);
      o_ev_r  <= phase_r == RS_PLAYING || phase_r == RS_PAUSED ||
                 (phase_r == RS_COMPLETED && keep_r);
    end
  end

  assign out_valid           = out_v_r;
  assign out_run_state       = o_rs_r;
  assign out_current_frame   = o_cf_r;
  assign out_range_start     = o_st_r;
  assign out_range_end       = o_en_r;
  assign out_range_valid     = o_v_r;
  assign out_range_backward  = o_b_r;
  assign out_range_wrapped   = o_w_r;
  assign out_wrap_count      = o_wc_r;
  assign out_by_seek         = o_s_r;
  assign out_range_serial    = o_ser_r;
  assign out_suppress_events = o_sup_r;
  assign out_evaluating      = o_ev_r;

endmodule

@@ rtl/core/tlph_alu.sv @@
// ----------------------------------------------------------------------------
// tlph_alu
// shared shift-add multiplier and restoring divider, one bit per cycle
// ----------------------------------------------------------------------------
module tlph_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  tlph_pkg::alu_req_t req,
  output tlph_pkg::alu_rsp_t rsp
);
  import tlph_pkg::*;

  logic        busy_r, busy_nxt;
  op_t         op_r, op_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [71:0] acc_r, acc_nxt;   // product, or dividend/quotient shift
  logic [71:0] mc_r, mc_nxt;     // multiplicand
  logic [39:0] b_r, b_nxt;       // multiplier bits, or divisor
  logic [40:0] rem_r, rem_nxt;
  logic        done_r, done_nxt;
  logic [40:0] trial;

  always_comb begin
    busy_nxt = busy_r;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    mc_nxt   = mc_r;
    b_nxt    = b_r;
    rem_nxt  = rem_r;
    done_nxt = 1'b0;
    trial    = '0;
    if (req.start) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      b_nxt    = req.b;
      rem_nxt  = '0;
      if (req.op == OP_MUL) begin
        acc_nxt = '0;
        mc_nxt  = req.a;
        cnt_nxt = 7'd40;
      end else begin
        acc_nxt = req.a;
        mc_nxt  = '0;
        cnt_nxt = 7'd72;
      end
    end else if (busy_r) begin
      if (op_r == OP_MUL) begin
        if (b_r[0]) acc_nxt = acc_r + mc_r;
        mc_nxt = {mc_r[70:0], 1'b0};
        b_nxt  = {1'b0, b_r[39:1]};
      end else begin
        trial = {rem_r[39:0], acc_r[71]};
        if (trial >= {1'b0, b_r}) begin
          rem_nxt = trial - {1'b0, b_r};
          acc_nxt = {acc_r[70:0], 1'b1};
        end else begin
          rem_nxt = trial;
          acc_nxt = {acc_r[70:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= OP_MUL;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      op_r   <= op_nxt;
    end
    acc_r <= acc_nxt;
    mc_r  <= mc_nxt;
    b_r   <= b_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.res  = acc_r;
  assign rsp.rem  = rem_r[39:0];

endmodule

@@ rtl/core/tlph_checker.sv @@
// ----------------------------------------------------------------------------
// tlph_checker
// port-level checks of the timeline playhead
// ----------------------------------------------------------------------------
module tlph_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_range_valid,
  input logic        out_suppress_events,
  input logic [39:0] out_range_start,
  input logic [39:0] out_range_end,
  input logic [31:0] out_range_serial
);

  // one word in flight: no acceptance right after another
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second word accepted while busy");

  // result held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_range_serial)))
    else $error("stalled result changed");

  // invalid range always suppresses events
  a_suppress: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_range_valid) |-> out_suppress_events)
    else $error("invalid range not suppressed");

  // a valid range spans a nonzero distance
  a_span: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_range_valid) |-> (out_range_start != out_range_end))
    else $error("valid range with empty span");

endmodule

bind timeline_playhead_unit tlph_checker u_tlph_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .out_range_valid(out_range_valid), .out_suppress_events(out_suppress_events),
  .out_range_start(out_range_start), .out_range_end(out_range_end),
  .out_range_serial(out_range_serial)
);
